// ===== hw/rtl/krt_pkg.sv =====
// ============================================================================
// krt_pkg
// Shared types and constants for the keyed record table: command and status
// codes, field widths, the stored record layout and the result layout.
// ============================================================================
`default_nettype none

package krt_pkg;

  // Table depth and the widths that follow from it
  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the transaction payloads
  localparam int CMD_W    = 3;
  localparam int KEY_W    = 16;
  localparam int MARK_W   = 10;
  localparam int TOTAL_W  = 11;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 8;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [MARK_W-1:0]  mark_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [ECNT_W-1:0]  ecnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_SEARCH = 3'd1,
    CMD_MODIFY = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  // One stored record, as held in the record memory
  typedef struct packed {
    key_t   key;
    mark_t  first;
    mark_t  second;
    total_t total;
  } rec_t;

  // One result, as presented on the output channel
  typedef struct packed {
    status_t status;
    key_t    key;
    mark_t   first;
    mark_t   second;
    total_t  total;
    pos_t    index;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/krt_ram.sv =====
// ============================================================================
// krt_ram
// Generic single-clock RAM: one write port, one read port, read data
// registered (old data on a same-address collision).
// ============================================================================
`default_nettype none

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_record_table_top.sv =====
// ============================================================================
// keyed_record_table_top
// Table of keyed records in one synchronous memory: append, search, modify,
// delete with compaction, and read by index. One result per request.
// ============================================================================
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   command key new_key first_mark
//                                             second_mark position
//   out      source     out_valid / out_ready status found_key found_first
//                                             found_second found_total
//                                             found_index entry_count
//
// Search, modify and delete scan the entries in order, one memory read per
// cycle. Delete then shifts each later record down, one read and one write
// on the single memory port pair per record, and drops the count once no
// record is left to shift.
// One request is in flight at a time; the next is accepted once the result
// sits in the output register, even while that result is still stalled.
// Reset clears the count and control only; memory contents are not cleared.
`default_nettype none

module keyed_record_table_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       command,
  input  wire krt_pkg::key_t    key,
  input  wire krt_pkg::key_t    new_key,
  input  wire krt_pkg::mark_t   first_mark,
  input  wire krt_pkg::mark_t   second_mark,
  input  wire krt_pkg::pos_t    position,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            status,
  output krt_pkg::key_t         found_key,
  output krt_pkg::mark_t        found_first,
  output krt_pkg::mark_t        found_second,
  output krt_pkg::total_t       found_total,
  output krt_pkg::pos_t         found_index,
  output krt_pkg::ecnt_t        entry_count
);

  krt_pkg::state_t state, state_next;
  krt_pkg::cmd_t   cmd_q;
  krt_pkg::key_t   key_q;
  krt_pkg::rec_t   rec_q;
  krt_pkg::pos_t   pos_q;

  krt_pkg::cnt_t   count, count_next;
  krt_pkg::cnt_t   scan_idx, scan_idx_next;
  krt_pkg::idx_t   chk_idx, chk_idx_next;
  krt_pkg::idx_t   shift_idx, shift_idx_next;
  logic            rd_vld, rd_vld_next;
  krt_pkg::res_t   res, res_next;

  krt_pkg::res_t   out_res;
  krt_pkg::ecnt_t  out_count;
  logic            out_load;

  logic                          ram_we, ram_re;
  krt_pkg::idx_t                 ram_waddr, ram_raddr;
  krt_pkg::rec_t                 ram_wdata, rd_rec;
  logic [$bits(krt_pkg::rec_t)-1:0] ram_rdata;

  logic          match;
  logic          issue;
  logic          pos_ok;
  krt_pkg::cnt_t shift_nxt;

  // Record memory
  krt_ram #(
    .WIDTH ($bits(krt_pkg::rec_t)),
    .DEPTH (krt_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rec    = ram_rdata;
  assign in_ready  = (state == krt_pkg::S_IDLE);
  assign match     = rd_vld && (rd_rec.key == key_q);
  assign issue     = (scan_idx < count);
  assign pos_ok    = (32'(pos_q) < 32'(count)) && (32'(pos_q) < 32'(krt_pkg::CAPACITY));
  assign shift_nxt = krt_pkg::cnt_t'(shift_idx) + krt_pkg::cnt_t'(1);

  // Capture the request transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q       <= krt_pkg::cmd_t'(command);
      key_q       <= key;
      pos_q       <= position;
      rec_q.key    <= new_key;
      rec_q.first  <= first_mark;
      rec_q.second <= second_mark;
      rec_q.total  <= krt_pkg::total_t'(first_mark) + krt_pkg::total_t'(second_mark);
    end
  end

  // State and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= krt_pkg::S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_vld_next;
    end
    scan_idx  <= scan_idx_next;
    chk_idx   <= chk_idx_next;
    shift_idx <= shift_idx_next;
    res       <= res_next;
  end

  // Sequence each command over the memory
  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_idx_next  = scan_idx;
    chk_idx_next   = chk_idx;
    shift_idx_next = shift_idx;
    rd_vld_next    = 1'b0;
    res_next       = res;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = rec_q;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    out_load       = 1'b0;

    case (state)
      krt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = krt_pkg::S_EXEC;
        end
      end

      krt_pkg::S_EXEC: begin
        res_next = '0;
        case (cmd_q)
          krt_pkg::CMD_APPEND: begin
            if (count >= krt_pkg::cnt_t'(krt_pkg::CAPACITY)) begin
              res_next.status = krt_pkg::STAT_FULL;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = count[krt_pkg::IDX_W-1:0];
              res_next.status = krt_pkg::STAT_OK;
              res_next.key    = rec_q.key;
              res_next.first  = rec_q.first;
              res_next.second = rec_q.second;
              res_next.total  = rec_q.total;
              res_next.index  = krt_pkg::pos_t'(count[krt_pkg::IDX_W-1:0]);
              count_next      = count + krt_pkg::cnt_t'(1);
            end
            state_next = krt_pkg::S_FINISH;
          end
          krt_pkg::CMD_SEARCH, krt_pkg::CMD_MODIFY, krt_pkg::CMD_DELETE: begin
            scan_idx_next = '0;
            state_next    = krt_pkg::S_SCAN;
          end
          krt_pkg::CMD_READ: begin
            if (pos_ok) begin
              ram_re     = 1'b1;
              ram_raddr  = krt_pkg::idx_t'(pos_q);
              state_next = krt_pkg::S_RD_WAIT;
            end else begin
              res_next.status = krt_pkg::STAT_RANGE;
              state_next      = krt_pkg::S_FINISH;
            end
          end
          default: begin
            res_next.status = krt_pkg::STAT_NOT_FOUND;
            state_next      = krt_pkg::S_FINISH;
          end
        endcase
      end

      krt_pkg::S_RD_WAIT: begin
        res_next.status = krt_pkg::STAT_OK;
        res_next.key    = rd_rec.key;
        res_next.first  = rd_rec.first;
        res_next.second = rd_rec.second;
        res_next.total  = rd_rec.total;
        res_next.index  = pos_q;
        state_next      = krt_pkg::S_FINISH;
      end

      // Issue one read per cycle, compare the data of the previous one
      krt_pkg::S_SCAN: begin
        if (match) begin
          res_next.status = krt_pkg::STAT_OK;
          res_next.key    = rd_rec.key;
          res_next.first  = rd_rec.first;
          res_next.second = rd_rec.second;
          res_next.total  = rd_rec.total;
          res_next.index  = krt_pkg::pos_t'(chk_idx);
          if (cmd_q == krt_pkg::CMD_MODIFY) begin
            ram_we     = 1'b1;
            ram_waddr  = chk_idx;
            state_next = krt_pkg::S_FINISH;
          end else if (cmd_q == krt_pkg::CMD_DELETE) begin
            shift_idx_next = chk_idx;
            state_next     = krt_pkg::S_SHIFT_RD;
          end else begin
            state_next = krt_pkg::S_FINISH;
          end
        end else if (issue) begin
          ram_re        = 1'b1;
          ram_raddr     = scan_idx[krt_pkg::IDX_W-1:0];
          rd_vld_next   = 1'b1;
          chk_idx_next  = scan_idx[krt_pkg::IDX_W-1:0];
          scan_idx_next = scan_idx + krt_pkg::cnt_t'(1);
        end else begin
          res_next        = '0;
          res_next.status = krt_pkg::STAT_NOT_FOUND;
          state_next      = krt_pkg::S_FINISH;
        end
      end

      // Compact: fetch the next record, or drop the last slot when done
      krt_pkg::S_SHIFT_RD: begin
        if (shift_nxt < count) begin
          ram_re     = 1'b1;
          ram_raddr  = shift_nxt[krt_pkg::IDX_W-1:0];
          state_next = krt_pkg::S_SHIFT_WR;
        end else begin
          count_next = count - krt_pkg::cnt_t'(1);
          state_next = krt_pkg::S_FINISH;
        end
      end

      krt_pkg::S_SHIFT_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = shift_idx;
        ram_wdata      = rd_rec;
        shift_idx_next = shift_idx + krt_pkg::idx_t'(1);
        state_next     = krt_pkg::S_SHIFT_RD;
      end

      // Hand the result to the output register once it is free
      krt_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = krt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = krt_pkg::S_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_res   <= res;
      out_count <= krt_pkg::ecnt_t'(count);
    end
  end

  assign status       = out_res.status;
  assign found_key    = out_res.key;
  assign found_first  = out_res.first;
  assign found_second = out_res.second;
  assign found_total  = out_res.total;
  assign found_index  = out_res.index;
  assign entry_count  = out_count;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= krt_pkg::cnt_t'(krt_pkg::CAPACITY))
    else $error("record count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ((count == $past(count) + krt_pkg::cnt_t'(1)) ||
       (count == $past(count) - krt_pkg::cnt_t'(1))))
    else $error("record count moved by more than one");

  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("memory read and write to the same entry");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.status != krt_pkg::STAT_OK)) |->
      ((found_key == '0) && (found_first == '0) && (found_second == '0) &&
       (found_total == '0) && (found_index == '0)))
    else $error("failed result carries record fields");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");

endmodule

`default_nettype wire

// ===== test/tb_keyed_record_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_record_table_top
// Self-checking bench for the keyed record table. Requests are driven on the
// input channel with random gaps. Each accepted request is run through a
// behavioural copy of the table, and every returned result is matched in
// order against the stored expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyed_record_table_top;

  localparam int                         CLK_HALF     = 5;
  localparam int                         RESET_CYCLES = 10;
  localparam int                         IDLE_PCT     = 35;
  localparam int                         RANDOM_ITEMS = 1550;
  localparam int                         MAX_REPORTS  = 10;
  localparam int                         SETTLE       = 2 * krt_pkg::CAPACITY + 16;
  localparam int                         CYCLE_LIMIT  = 3_000_000;
  localparam logic [krt_pkg::CMD_W-1:0]  CMD_TOP      = '1;

  typedef struct packed {
    logic [krt_pkg::CMD_W-1:0] cmd;
    krt_pkg::key_t             key;
    krt_pkg::key_t             new_key;
    krt_pkg::mark_t            first;
    krt_pkg::mark_t            second;
    krt_pkg::pos_t             pos;
  } request_t;

  typedef struct packed {
    krt_pkg::status_t status;
    krt_pkg::key_t    key;
    krt_pkg::mark_t   first;
    krt_pkg::mark_t   second;
    krt_pkg::total_t  total;
    krt_pkg::pos_t    index;
    krt_pkg::ecnt_t   count;
  } outcome_t;

  typedef enum {MIX_FILL, MIX_MIXED, MIX_DRAIN} mix_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            out_ready = 1'b0;
  request_t        cur_req = '0;
  wire             in_ready;
  wire             out_valid;
  wire [1:0]       status;
  krt_pkg::key_t   found_key;
  krt_pkg::mark_t  found_first;
  krt_pkg::mark_t  found_second;
  krt_pkg::total_t found_total;
  krt_pkg::pos_t   found_index;
  krt_pkg::ecnt_t  entry_count;

  // Shadow of the table contents
  krt_pkg::key_t   tbl_key    [krt_pkg::CAPACITY];
  krt_pkg::mark_t  tbl_first  [krt_pkg::CAPACITY];
  krt_pkg::mark_t  tbl_second [krt_pkg::CAPACITY];
  krt_pkg::total_t tbl_total  [krt_pkg::CAPACITY];
  int       held = 0;
  int       peak_held = 0;

  request_t pending_requests [$];
  outcome_t expected_outcomes [$];
  int       n_queued = 0;
  int       n_sent = 0;
  int       n_accepted = 0;
  int       n_checked = 0;
  int       errors = 0;
  int       cycle_count = 0;
  int       cmd_seen [8];
  int       status_seen [4];
  outcome_t got;
  outcome_t want;
  logic     steady;

  keyed_record_table_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (cur_req.cmd),
    .key          (cur_req.key),
    .new_key      (cur_req.new_key),
    .first_mark   (cur_req.first),
    .second_mark  (cur_req.second),
    .position     (cur_req.pos),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_key    (found_key),
    .found_first  (found_first),
    .found_second (found_second),
    .found_total  (found_total),
    .found_index  (found_index),
    .entry_count  (entry_count)
  );

  always #CLK_HALF clk = ~clk;

  // No idling on either side while this window of transactions goes through
  assign steady = (n_accepted >= 700) && (n_accepted < 900);

  // --------------------------------------------------------------------------
  // Table behaviour
  // --------------------------------------------------------------------------
  function automatic int find_key(krt_pkg::key_t k);
    for (int i = 0; i < held; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void store_record(int slot, krt_pkg::key_t k, krt_pkg::mark_t a,
                                       krt_pkg::mark_t b);
    tbl_key[slot]    = k;
    tbl_first[slot]  = a;
    tbl_second[slot] = b;
    tbl_total[slot]  = krt_pkg::total_t'(a) + krt_pkg::total_t'(b);
  endfunction

  // Apply one request to the shadow table and return the result it gives
  function automatic outcome_t apply_request(request_t rq);
    int       slot;
    outcome_t res;
    res = '0;
    res.status = krt_pkg::STAT_NOT_FOUND;
    case (rq.cmd)
      krt_pkg::CMD_APPEND: slot = (held < krt_pkg::CAPACITY) ? held : -1;
      krt_pkg::CMD_SEARCH, krt_pkg::CMD_MODIFY, krt_pkg::CMD_DELETE: slot = find_key(rq.key);
      krt_pkg::CMD_READ: slot = (rq.pos < held) ? int'(rq.pos) : -1;
      default: slot = -1;
    endcase
    // append stores first, so the result shows the new record
    if (rq.cmd == krt_pkg::CMD_APPEND && slot >= 0) begin
      store_record(slot, rq.new_key, rq.first, rq.second);
      held++;
    end
    if (slot >= 0) begin
      res.status = krt_pkg::STAT_OK;
      res.key    = tbl_key[slot];
      res.first  = tbl_first[slot];
      res.second = tbl_second[slot];
      res.total  = tbl_total[slot];
      res.index  = krt_pkg::pos_t'(slot);
    end else if (rq.cmd == krt_pkg::CMD_APPEND) begin
      res.status = krt_pkg::STAT_FULL;
    end else if (rq.cmd == krt_pkg::CMD_READ) begin
      res.status = krt_pkg::STAT_RANGE;
    end
    if (slot >= 0 && rq.cmd == krt_pkg::CMD_MODIFY) begin
      store_record(slot, rq.new_key, rq.first, rq.second);
    end
    // close the gap left by the deleted record
    if (slot >= 0 && rq.cmd == krt_pkg::CMD_DELETE) begin
      for (int j = slot; j + 1 < held; j++) begin
        tbl_key[j]    = tbl_key[j + 1];
        tbl_first[j]  = tbl_first[j + 1];
        tbl_second[j] = tbl_second[j + 1];
        tbl_total[j]  = tbl_total[j + 1];
      end
      held--;
    end
    res.count = krt_pkg::ecnt_t'(held);
    return res;
  endfunction

  function automatic string show(outcome_t o);
    return $sformatf("status=%0d key=%h first=%0d second=%0d total=%0d index=%0d count=%0d",
                     o.status, o.key, o.first, o.second, o.total, o.index, o.count);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic request_t make_req(logic [krt_pkg::CMD_W-1:0] cmd, krt_pkg::key_t k,
                                        krt_pkg::key_t nk, krt_pkg::mark_t a,
                                        krt_pkg::mark_t b, krt_pkg::pos_t p);
    request_t rq;
    rq.cmd     = cmd;
    rq.key     = k;
    rq.new_key = nk;
    rq.first   = a;
    rq.second  = b;
    rq.pos     = p;
    return rq;
  endfunction

  // Weight the command mix by phase; a few unknown codes in every phase
  function automatic logic [krt_pkg::CMD_W-1:0] pick_command(mix_t mix);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return krt_pkg::CMD_W'($urandom_range(CMD_TOP, krt_pkg::CMD_READ + 1));
    case (mix)
      MIX_FILL: begin
        if (roll < 85) return krt_pkg::CMD_APPEND;
        if (roll < 93) return krt_pkg::CMD_SEARCH;
        return krt_pkg::CMD_READ;
      end
      MIX_DRAIN: begin
        if (roll < 60) return krt_pkg::CMD_DELETE;
        if (roll < 72) return krt_pkg::CMD_APPEND;
        if (roll < 82) return krt_pkg::CMD_SEARCH;
        if (roll < 90) return krt_pkg::CMD_MODIFY;
        return krt_pkg::CMD_READ;
      end
      default: begin
        if (roll < 28) return krt_pkg::CMD_APPEND;
        if (roll < 46) return krt_pkg::CMD_SEARCH;
        if (roll < 62) return krt_pkg::CMD_MODIFY;
        if (roll < 80) return krt_pkg::CMD_DELETE;
        return krt_pkg::CMD_READ;
      end
    endcase
  endfunction

  function automatic krt_pkg::mark_t random_mark();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return krt_pkg::mark_t'($urandom);
  endfunction

  // Mostly aim at stored keys and live positions; small key pool for duplicates
  function automatic request_t random_request(mix_t mix);
    request_t rq;
    rq.cmd     = pick_command(mix);
    rq.key     = krt_pkg::key_t'($urandom);
    rq.new_key = ($urandom_range(99) < 40) ? krt_pkg::key_t'($urandom_range(15)) :
                                             krt_pkg::key_t'($urandom);
    rq.first   = random_mark();
    rq.second  = random_mark();
    rq.pos     = krt_pkg::pos_t'($urandom);
    if (held > 0 && $urandom_range(99) < 80) rq.key = tbl_key[$urandom_range(held - 1)];
    if (held > 0 && $urandom_range(99) < 70) rq.pos = krt_pkg::pos_t'($urandom_range(held - 1));
    return rq;
  endfunction

  // Hand one request to the driver once the previous one has been accepted
  task automatic queue_request(request_t rq);
    wait (n_accepted == n_queued);
    pending_requests.push_back(rq);
    n_queued++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: present requests and the output ready at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      // hold the current transaction until it is taken
      if (n_accepted == n_sent) begin
        if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          cur_req  <= pending_requests.pop_front();
          in_valid <= 1'b1;
          n_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results and predict for accepted requests at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{krt_pkg::status_t'(status), found_key, found_first, found_second,
                found_total, found_index, entry_count};
        status_seen[got.status]++;
        if (expected_outcomes.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) $display("unexpected result: %s", show(got));
        end else begin
          want = expected_outcomes.pop_front();
          n_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("mismatch on result %0d", n_checked);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_outcomes.push_back(apply_request(cur_req));
        cmd_seen[cur_req.cmd]++;
        if (held > peak_held) peak_held = held;
        n_accepted++;
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed requests, random phases, wind down
  // --------------------------------------------------------------------------
  initial begin
    int   left;
    int   run;
    mix_t mix;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table: every lookup misses
    queue_request(make_req(krt_pkg::CMD_SEARCH, '0, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_MODIFY, '1, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_DELETE, '0, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_READ, '0, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_READ, '0, '0, '0, '0, '1));
    // extremes of key and marks, plus a duplicate key
    queue_request(make_req(krt_pkg::CMD_APPEND, '0, '1, '1, '1, '0));
    queue_request(make_req(krt_pkg::CMD_APPEND, '1, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_APPEND, '0, 16'h1234, '1, '0, '0));
    queue_request(make_req(krt_pkg::CMD_APPEND, '0, '1, '0, '1, '0));
    // first match wins
    queue_request(make_req(krt_pkg::CMD_SEARCH, '1, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_SEARCH, '0, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_SEARCH, 16'h5555, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_MODIFY, '1, 16'h8001, 10'd512, 10'd511, '0));
    queue_request(make_req(krt_pkg::CMD_SEARCH, '1, '0, '0, '0, '0));
    // reads inside and just past the end
    queue_request(make_req(krt_pkg::CMD_READ, '0, '0, '0, '0, 7'd0));
    queue_request(make_req(krt_pkg::CMD_READ, '0, '0, '0, '0, 7'd3));
    queue_request(make_req(krt_pkg::CMD_READ, '0, '0, '0, '0, 7'd4));
    // delete in the middle, at the end and at the front
    queue_request(make_req(krt_pkg::CMD_DELETE, '0, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_DELETE, '1, '0, '0, '0, '0));
    queue_request(make_req(krt_pkg::CMD_DELETE, 16'h8001, '0, '0, '0, '0));
    // unknown codes with every other field at its top
    queue_request(make_req(CMD_TOP, '1, '1, '1, '1, '1));
    queue_request(make_req(CMD_TOP - 3'd1, '1, '1, '1, '1, '1));
    queue_request(make_req(CMD_TOP - 3'd2, '1, '1, '1, '1, '1));
    queue_request(make_req(krt_pkg::CMD_READ, '0, '0, '0, '0, 7'd0));
    queue_request(make_req(krt_pkg::CMD_DELETE, 16'h1234, '0, '0, '0, '0));

    // open with a fill phase so the table reaches full early
    left = RANDOM_ITEMS;
    mix  = MIX_FILL;
    run  = 200;
    while (left > 0) begin
      if (run > left) run = left;
      repeat (run) queue_request(random_request(mix));
      left -= run;
      mix = mix_t'($urandom_range(2));
      run = $urandom_range(40, 250);
    end

    // wait for every result, then give the block time to show any stray one
    wait (n_checked == n_queued);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d requests: %0d append, %0d search, %0d modify, %0d delete,",
             n_accepted, cmd_seen[krt_pkg::CMD_APPEND], cmd_seen[krt_pkg::CMD_SEARCH],
             cmd_seen[krt_pkg::CMD_MODIFY], cmd_seen[krt_pkg::CMD_DELETE]);
    $display("  %0d read, %0d unknown; peak entries %0d",
             cmd_seen[krt_pkg::CMD_READ],
             cmd_seen[krt_pkg::CMD_READ + 1] + cmd_seen[CMD_TOP - 1] + cmd_seen[CMD_TOP],
             peak_held);
    $display("results: %0d ok, %0d not found, %0d table full, %0d out of range; %0d errors",
             status_seen[krt_pkg::STAT_OK], status_seen[krt_pkg::STAT_NOT_FOUND],
             status_seen[krt_pkg::STAT_FULL], status_seen[krt_pkg::STAT_RANGE], errors);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/krt_pkg.sv
hw/rtl/krt_ram.sv
hw/rtl/keyed_record_table_top.sv
test/tb_keyed_record_table_top.sv
